@@ rtl/bounded_uniform_integer_reducer_defines.svh @@
// ----------------------------------------------------------------------------
// Bounded uniform integer reducer: assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNIFORM_INTEGER_REDUCER_DEFINES_SVH
`define BOUNDED_UNIFORM_INTEGER_REDUCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define BUR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define BUR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BUR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BUR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/bur_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded uniform integer reducer package
// Shared constants, command codes and remainder unit request/response types.
// ----------------------------------------------------------------------------
`default_nettype none

package bur_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MAX_TRIES = 20;

  localparam logic [WORD_W-1:0] WORD_ALL = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [WORD_W-1:0] POS_MAX  = 32'h7FFF_FFFF;

  // Input request kinds carried on tuser
  localparam logic CMD_BOUNDS = 1'b0;
  localparam logic CMD_WORD   = 1'b1;

  // Remainder unit request
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } bur_div_req_t;

  // Remainder unit response
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] remainder;
  } bur_div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/bur_mod_unit.sv @@
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module bur_mod_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire bur_pkg::bur_div_req_t req_i,
  output bur_pkg::bur_div_rsp_t      rsp_o
);
  import bur_pkg::*;

  localparam int unsigned CntW = $clog2(WORD_W);

  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] dvd_q, dvd_d;
  logic [WORD_W-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign trial = {rem_q, dvd_q[WORD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (req_i.start) begin
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
      dvd_d = {dvd_q[WORD_W-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control flags under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

@@ rtl/bounded_uniform_integer_reducer.sv @@
// ----------------------------------------------------------------------------
// Bounded uniform integer reducer
// Maps raw 32-bit random words to a uniform integer in a signed interval.
// ----------------------------------------------------------------------------
// A bounds request (tuser = 0) latches low and high; a word request
// (tuser = 1) supplies one random word. Requests with low >= high answer at
// once with low. Full-range and power-of-two spans are answered from the
// word without the remainder unit. Other spans share one bit-serial remainder
// unit: a bounds request runs one modulo pass to compute the rejection limit,
// an accepted word one modulo pass, and a word folded after the retry limit
// two modulo passes. Rejected words give no result; words with no request
// pending are dropped. One result register sits on the output, so a request
// is taken while a result waits if the sink takes it in the same cycle.
`default_nettype none

module bounded_uniform_integer_reducer #(
  parameter int unsigned MaxTries = bur_pkg::MAX_TRIES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // [31:0] low_bound, [63:32] high_bound, [95:64] random_word
  input  wire logic [95:0] s_axis_tdata_i,
  // [0] command
  input  wire logic        s_axis_tuser_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [31:0] value
  output      logic [31:0] m_axis_tdata_o,
  // [0] forced_fold
  output      logic        m_axis_tuser_o
);
  import bur_pkg::*;

`include "bounded_uniform_integer_reducer_defines.svh"

  localparam int unsigned TriesW = $clog2(MaxTries + 1);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_CLASSIFY = 5'b00010,
    ST_LIMIT    = 5'b00100,
    ST_FOLD     = 5'b01000,
    ST_REDUCE   = 5'b10000
  } bur_state_e;

  bur_state_e        state_q, state_d;
  logic [WORD_W-1:0] base_q, base_d;
  logic [WORD_W-1:0] span_q, span_d;
  // Rejection limit, or span - 1 as the mask for power-of-two spans
  logic [WORD_W-1:0] limit_q, limit_d;
  logic [TriesW-1:0] tries_q, tries_d;
  logic              pending_q, pending_d;
  logic              full_q, full_d;
  logic              pow2_q, pow2_d;
  logic              fold_q, fold_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_data_q, out_data_d;
  logic              out_fold_q, out_fold_d;

  bur_div_req_t      div_req;
  bur_div_rsp_t      div_rsp;

  logic              out_free;
  logic              in_fire;
  logic [WORD_W-1:0] lo, hi, word;
  logic [WORD_W-1:0] span_m1;

  assign lo   = s_axis_tdata_i[31:0];
  assign hi   = s_axis_tdata_i[63:32];
  assign word = s_axis_tdata_i[95:64];

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign span_m1         = span_q - WORD_W'(1);

  // Shared remainder unit
  bur_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    span_d     = span_q;
    limit_d    = limit_q;
    tries_d    = tries_q;
    pending_d  = pending_q;
    full_d     = full_q;
    pow2_d     = pow2_q;
    fold_d     = fold_q;
    out_data_d = out_data_q;
    out_fold_d = out_fold_q;
    div_req    = '0;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (s_axis_tuser_i == CMD_BOUNDS)) begin
          tries_d = '0;
          full_d  = 1'b0;
          pow2_d  = 1'b0;
          base_d  = lo;
          if ($signed(lo) >= $signed(hi)) begin
            // Empty or single interval: answer with low
            pending_d   = 1'b0;
            out_valid_d = 1'b1;
            out_data_d  = lo;
            out_fold_d  = 1'b0;
          end else begin
            pending_d = 1'b1;
            if (lo == SIGN_BIT && hi == POS_MAX) begin
              full_d = 1'b1;
            end else begin
              span_d  = hi - lo + WORD_W'(1);
              state_d = ST_CLASSIFY;
            end
          end
        end else if (in_fire && pending_q) begin
          priority if (full_q) begin
            pending_d   = 1'b0;
            out_valid_d = 1'b1;
            out_data_d  = word;
            out_fold_d  = 1'b0;
          end else if (pow2_q) begin
            pending_d   = 1'b0;
            out_valid_d = 1'b1;
            out_data_d  = base_q + (word & limit_q);
            out_fold_d  = 1'b0;
          end else if (word >= limit_q) begin
            if (tries_q >= TriesW'(MaxTries - 1)) begin
              // Retry limit reached: fold the word into range
              div_req.start    = 1'b1;
              div_req.dividend = word;
              div_req.divisor  = limit_q;
              fold_d           = 1'b1;
              state_d          = ST_FOLD;
            end else begin
              tries_d = tries_q + TriesW'(1);
            end
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = word;
            div_req.divisor  = span_q;
            fold_d           = 1'b0;
            state_d          = ST_REDUCE;
          end
        end
      end
      ST_CLASSIFY: begin
        if ((span_q & span_m1) == '0) begin
          pow2_d  = 1'b1;
          limit_d = span_m1;
          state_d = ST_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = WORD_ALL;
          div_req.divisor  = span_q;
          state_d          = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        // All-ones minus the remainder is its complement
        if (div_rsp.done) begin
          limit_d = ~div_rsp.remainder;
          state_d = ST_IDLE;
        end
      end
      ST_FOLD: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.remainder;
          div_req.divisor  = span_q;
          state_d          = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (div_rsp.done && out_free) begin
          pending_d   = 1'b0;
          tries_d     = '0;
          out_valid_d = 1'b1;
          out_data_d  = base_q + div_rsp.remainder;
          out_fold_d  = fold_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      span_q      <= '0;
      limit_q     <= '0;
      tries_q     <= '0;
      pending_q   <= 1'b0;
      full_q      <= 1'b0;
      pow2_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      span_q      <= span_d;
      limit_q     <= limit_d;
      tries_q     <= tries_d;
      pending_q   <= pending_d;
      full_q      <= full_d;
      pow2_q      <= pow2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    fold_q     <= fold_d;
    out_data_q <= out_data_d;
    out_fold_q <= out_fold_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_fold_q;

  // Checks
  `BUR_ASSERT_IMPL(a_no_restart, clk_i, rst_ni, div_req.start, !div_rsp.busy,
                   "mod unit restarted while busy")
  `BUR_ASSERT_NEXT(a_reduce_out, clk_i, rst_ni,
                   (state_q == ST_REDUCE) && div_rsp.done && out_free,
                   m_axis_tvalid_o, "reduced result not presented")
  `BUR_ASSERT_NEXT(a_full_out, clk_i, rst_ni,
                   in_fire && (s_axis_tuser_i == CMD_WORD) && pending_q && full_q,
                   m_axis_tvalid_o && (state_q == ST_IDLE), "full-range word not passed")
  `BUR_ASSERT_IMPL(a_tries_bound, clk_i, rst_ni, pending_q, tries_q < TriesW'(MaxTries),
                   "retry count past limit")

endmodule

`default_nettype wire
